/* hdl/fractal_value_noise_pixel_unit_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the fractal value noise pixel unit.
// Both expect clk and rst_n in scope and hold off while reset is low.
// ---------------------------------------------------------------------------
`ifndef FRACTAL_VALUE_NOISE_PIXEL_UNIT_DEFINES_SVH
`define FRACTAL_VALUE_NOISE_PIXEL_UNIT_DEFINES_SVH

// same-cycle implication
`define FVNP_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fvnp assertion failed");

// next-cycle implication
`define FVNP_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fvnp assertion failed");

`endif

/* hdl/fvnp_pkg.sv */
// ---------------------------------------------------------------------------
// fvnp_pkg
// Shared types, constants and the cosine table builder for the noise unit.
// ---------------------------------------------------------------------------
package fvnp_pkg;

    localparam int COORD_BITS_DEF     = 16;
    localparam int NUM_SEEDS_DEF      = 10;
    localparam int COS_TABLE_BITS_DEF = 8;
    localparam int MAX_OCTAVES_DEF    = 16;

    localparam int TABLE_SEEDS = 10;
    localparam int SEED_IDX_W  = 4;
    localparam int SEL_W       = 4;
    localparam int SEL_N       = 1 << SEL_W;
    localparam int OCT_W       = 5;
    localparam int PERS_W      = 16;
    localparam int SHIFT_W     = 4;
    localparam int WEIGHT_W    = 17;
    localparam int LAT_W       = 32;
    localparam int SMOOTH_W    = 36;
    localparam int ACC_W       = 23;
    localparam int NOISE_W     = 22;
    localparam int COS_W       = 17;
    localparam int NOISE_HI    = (1 << (NOISE_W - 1)) - 1;
    localparam int NOISE_LO    = -(1 << (NOISE_W - 1));

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_OCTAVES     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_SELECT = 2'd2;

    localparam logic [OCT_W-1:0]    OCTAVES_RST     = 5'd7;
    localparam logic [PERS_W-1:0]   PERSISTENCE_RST = 16'd32768;
    localparam logic [SEL_W-1:0]    SEED_SELECT_RST = 4'd0;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE      = 17'h10000;

    localparam logic [31:0] HASH_MUL   = 32'd57;
    localparam int          HASH_SHIFT = 13;
    localparam logic [31:0] LAT_BIAS   = 32'h4000_0000;
    localparam logic [31:0] T_MASK     = 32'h7fff_ffff;

    typedef struct packed {
        logic [31:0] s0;
        logic [31:0] s1;
        logic [31:0] s2;
    } seed_trip_t;

    typedef struct packed {
        logic                  active;
        logic [SHIFT_W-1:0]    shift;
        logic [SEED_IDX_W-1:0] seed;
    } cell_cfg_t;

    localparam seed_trip_t SEED_TAB [TABLE_SEEDS] = '{
        '{32'd995615039, 32'd600173719, 32'd701464987},
        '{32'd831731269, 32'd162318869, 32'd136250887},
        '{32'd174329291, 32'd946737083, 32'd245679977},
        '{32'd362489573, 32'd795918041, 32'd350777237},
        '{32'd457025711, 32'd880830799, 32'd909678923},
        '{32'd787070341, 32'd177340217, 32'd593320781},
        '{32'd405493717, 32'd291031019, 32'd391950901},
        '{32'd458904767, 32'd676625681, 32'd424452397},
        '{32'd531736441, 32'd939683957, 32'd810651871},
        '{32'd997169939, 32'd842027887, 32'd423882827}
    };

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam longint unsigned FACT_DIV [7] = '{2, 12, 30, 56, 90, 132, 182};

    // (1 - cos(pi*j/2^b))/2 in Q0.16, Taylor series on a Q30 angle
    function automatic logic [COS_W-1:0] cos_entry(input int j, input int b);
        int               half;
        int               jj;
        longint unsigned  th;
        longint unsigned  q;
        longint unsigned  g;
        longint           c;
        longint           v;
        logic [COS_W-1:0] w;
        half = 1 << (b - 1);
        jj   = (j <= half) ? j : (1 << b) - j;
        th   = (longint'(jj) * PI_Q30) >> b;
        q    = (th * th) >> 30;
        g    = 64'd1 << 30;
        c    = 64'sd1 << 30;
        for (int m = 1; m <= 7; m++) begin
            g = ((g * q) >> 30) / FACT_DIV[m-1];
            if ((m & 1) != 0)
                c = c - longint'(g);
            else
                c = c + longint'(g);
        end
        v = (64'sd1 << 30) - c;
        if (v < 0)
            v = 0;
        w = COS_W'((v + (64'sd1 << 14)) >>> 15);
        if (j > half)
            w = 17'h10000 - w;
        return w;
    endfunction

endpackage

/* hdl/fractal_value_noise_pixel_unit.sv */
// ---------------------------------------------------------------------------
// fractal_value_noise_pixel_unit: fractal value noise for one pixel per transaction.
// Path: each pixel passes through MAX_OCTAVES octave cells and then the output register.
// Throughput: one pixel per cycle while the output is not stalled, set by the chain of 11-stage octave cells.
// Reset: octave_count 7, persistence 0.5, seed_select 0, all pipeline valids cleared.
// ---------------------------------------------------------------------------
`include "fractal_value_noise_pixel_unit_defines.svh"

module fractal_value_noise_pixel_unit #(
    parameter int COORD_BITS     = fvnp_pkg::COORD_BITS_DEF,
    parameter int NUM_SEEDS      = fvnp_pkg::NUM_SEEDS_DEF,
    parameter int COS_TABLE_BITS = fvnp_pkg::COS_TABLE_BITS_DEF,
    parameter int MAX_OCTAVES    = fvnp_pkg::MAX_OCTAVES_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fvnp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fvnp_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                  pixel_valid,
    output logic                                  pixel_ready,
    input  logic [COORD_BITS-1:0]                 x_coord,
    input  logic [COORD_BITS-1:0]                 y_coord,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic signed [fvnp_pkg::NOISE_W-1:0]   noise_value
);

    localparam int AW = fvnp_pkg::ACC_W;
    localparam int NW = fvnp_pkg::NOISE_W;
    localparam int OW = fvnp_pkg::OCT_W;
    localparam logic signed [AW-1:0] SAT_HI = AW'(fvnp_pkg::NOISE_HI);
    localparam logic signed [AW-1:0] SAT_LO = AW'(fvnp_pkg::NOISE_LO);

    function automatic logic [fvnp_pkg::SEL_N-1:0][fvnp_pkg::SEED_IDX_W-1:0] seed_lut(
        input int k
    );
        logic [fvnp_pkg::SEL_N-1:0][fvnp_pkg::SEED_IDX_W-1:0] lut;
        for (int j = 0; j < fvnp_pkg::SEL_N; j++)
            lut[j] = fvnp_pkg::SEED_IDX_W'(((j + k) % NUM_SEEDS) % fvnp_pkg::TABLE_SEEDS);
        return lut;
    endfunction

    logic [OW-1:0]                   octave_count_reg;
    logic [fvnp_pkg::PERS_W-1:0]     persistence_reg;
    logic [fvnp_pkg::SEL_W-1:0]      seed_select_reg;
    logic [OW-1:0]                   oct_eff;

    logic                            chain_valid  [MAX_OCTAVES+1];
    logic [COORD_BITS-1:0]           chain_x      [MAX_OCTAVES+1];
    logic [COORD_BITS-1:0]           chain_y      [MAX_OCTAVES+1];
    logic [fvnp_pkg::WEIGHT_W-1:0]   chain_weight [MAX_OCTAVES+1];
    logic signed [AW-1:0]            chain_acc    [MAX_OCTAVES+1];

    logic                            advance;
    logic                            result_valid_reg;
    logic signed [NW-1:0]            noise_value_reg;
    logic signed [NW-1:0]            noise_sat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg <= fvnp_pkg::OCTAVES_RST;
            persistence_reg  <= fvnp_pkg::PERSISTENCE_RST;
            seed_select_reg  <= fvnp_pkg::SEED_SELECT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                fvnp_pkg::REG_OCTAVES:     octave_count_reg <= cfg_data[OW-1:0];
                fvnp_pkg::REG_PERSISTENCE: persistence_reg  <= cfg_data;
                fvnp_pkg::REG_SEED_SELECT: seed_select_reg  <= cfg_data[fvnp_pkg::SEL_W-1:0];
                default: ;
            endcase
        end
    end

    assign oct_eff = (octave_count_reg > OW'(MAX_OCTAVES)) ? OW'(MAX_OCTAVES)
                                                           : octave_count_reg;

    // hold the whole chain only when a finished result would be overwritten
    assign advance     = !result_valid_reg || result_ready || !chain_valid[MAX_OCTAVES];
    assign pixel_ready = advance;

    assign chain_valid[0]  = pixel_valid;
    assign chain_x[0]      = x_coord;
    assign chain_y[0]      = y_coord;
    assign chain_weight[0] = fvnp_pkg::WEIGHT_ONE;
    assign chain_acc[0]    = '0;

    genvar k;
    generate
        for (k = 0; k < MAX_OCTAVES; k++)
        begin : g_cell
            localparam logic [fvnp_pkg::SEL_N-1:0][fvnp_pkg::SEED_IDX_W-1:0] SEED_LUT =
                seed_lut(k);
            fvnp_pkg::cell_cfg_t cell_cfg;

            assign cell_cfg.active = (OW'(k) < oct_eff);
            assign cell_cfg.shift  = fvnp_pkg::SHIFT_W'(oct_eff - OW'(k) - OW'(1));
            assign cell_cfg.seed   = SEED_LUT[seed_select_reg];

            fvnp_cell #(
                .COORD_BITS     (COORD_BITS),
                .COS_TABLE_BITS (COS_TABLE_BITS)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .en          (advance),
                .cfg         (cell_cfg),
                .persistence (persistence_reg),
                .up_valid    (chain_valid[k]),
                .up_x        (chain_x[k]),
                .up_y        (chain_y[k]),
                .up_weight   (chain_weight[k]),
                .up_acc      (chain_acc[k]),
                .down_valid  (chain_valid[k+1]),
                .down_x      (chain_x[k+1]),
                .down_y      (chain_y[k+1]),
                .down_weight (chain_weight[k+1]),
                .down_acc    (chain_acc[k+1])
            );
        end
    endgenerate

    always_comb
    begin
        priority if (chain_acc[MAX_OCTAVES] > SAT_HI)
            noise_sat = NW'(SAT_HI);
        else if (chain_acc[MAX_OCTAVES] < SAT_LO)
            noise_sat = NW'(SAT_LO);
        else
            noise_sat = NW'(chain_acc[MAX_OCTAVES]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (!result_valid_reg || result_ready)
            result_valid_reg <= chain_valid[MAX_OCTAVES];
    end

    always_ff @(posedge clk)
    begin
        if (!result_valid_reg || result_ready)
            noise_value_reg <= noise_sat;
    end

    assign result_valid = result_valid_reg;
    assign noise_value  = noise_value_reg;

    `FVNP_ASSERT_IMPL(a_full_out_blocks_pixel, result_valid_reg && !result_ready && chain_valid[MAX_OCTAVES], !pixel_ready)
    `FVNP_ASSERT_NEXT(a_last_cell_loads_out, advance && chain_valid[MAX_OCTAVES], result_valid)
    `FVNP_ASSERT_NEXT(a_stall_holds_chain, !advance, chain_valid[MAX_OCTAVES] && $stable(chain_acc[MAX_OCTAVES]))

endmodule

/* hdl/fvnp_hash.sv */
// ---------------------------------------------------------------------------
// fvnp_hash
// Four-stage integer lattice hash, wrapping 32-bit, returns a Q30 value.
// ---------------------------------------------------------------------------
module fvnp_hash (
    input  logic                   clk,
    input  logic                   en,
    input  logic [31:0]            cx,
    input  logic [31:0]            cy,
    input  fvnp_pkg::seed_trip_t   seeds,
    output logic signed [31:0]     lat
);

    logic [31:0] a;
    logic [31:0] h_next;
    logic [31:0] h_reg;
    logic [31:0] h1_reg;
    logic [31:0] m1_reg;
    logic [31:0] h2_reg;
    logic [31:0] m2_reg;
    logic [31:0] t;
    logic [31:0] lat_reg;

    assign a      = cx + cy * fvnp_pkg::HASH_MUL;
    assign h_next = (a << fvnp_pkg::HASH_SHIFT) ^ a;
    assign t      = (h2_reg * m2_reg + seeds.s2) & fvnp_pkg::T_MASK;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_reg   <= h_next;
            h1_reg  <= h_reg;
            m1_reg  <= h_reg * h_reg;
            h2_reg  <= h1_reg;
            m2_reg  <= m1_reg * seeds.s0 + seeds.s1;
            lat_reg <= fvnp_pkg::LAT_BIAS - t;
        end
    end

    assign lat = signed'(lat_reg);

endmodule

/* hdl/fvnp_cell.sv */
// ---------------------------------------------------------------------------
// fvnp_cell
// One octave: 16 lattice hashes, 3x3 smoothing, cosine blend, weighted add.
// ---------------------------------------------------------------------------
module fvnp_cell #(
    parameter int COORD_BITS     = fvnp_pkg::COORD_BITS_DEF,
    parameter int COS_TABLE_BITS = fvnp_pkg::COS_TABLE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  fvnp_pkg::cell_cfg_t                  cfg,
    input  logic [fvnp_pkg::PERS_W-1:0]          persistence,
    input  logic                                 up_valid,
    input  logic [COORD_BITS-1:0]                up_x,
    input  logic [COORD_BITS-1:0]                up_y,
    input  logic [fvnp_pkg::WEIGHT_W-1:0]        up_weight,
    input  logic signed [fvnp_pkg::ACC_W-1:0]    up_acc,
    output logic                                 down_valid,
    output logic [COORD_BITS-1:0]                down_x,
    output logic [COORD_BITS-1:0]                down_y,
    output logic [fvnp_pkg::WEIGHT_W-1:0]        down_weight,
    output logic signed [fvnp_pkg::ACC_W-1:0]    down_acc
);

    localparam int B        = COS_TABLE_BITS;
    localparam int ROM_SIZE = 1 << B;
    localparam int CW       = fvnp_pkg::COS_W;
    localparam int WW       = fvnp_pkg::WEIGHT_W;
    localparam int SW       = fvnp_pkg::SMOOTH_W;
    localparam int AW       = fvnp_pkg::ACC_W;
    localparam int PW       = fvnp_pkg::PERS_W;
    localparam int STAGES   = 11;
    localparam int BX_W     = SW + 1 + CW + 1;
    localparam int PROD_W   = SW + WW + 1;

    function automatic logic [ROM_SIZE-1:0][CW-1:0] build_cos_rom();
        logic [ROM_SIZE-1:0][CW-1:0] rom;
        for (int j = 0; j < ROM_SIZE; j++)
            rom[j] = fvnp_pkg::cos_entry(j, B);
        return rom;
    endfunction

    localparam logic [ROM_SIZE-1:0][CW-1:0] COS_ROM = build_cos_rom();

    // stage 0 inputs
    logic [COORD_BITS-1:0]   cx;
    logic [COORD_BITS-1:0]   cy;
    logic [COORD_BITS+B-1:0] fx;
    logic [COORD_BITS+B-1:0] fy;
    logic [31:0]             xs [4];
    logic [31:0]             ys [4];
    logic [WW+PW:0]          wround;
    logic [WW-1:0]           weight_next;
    fvnp_pkg::seed_trip_t    seeds;

    logic                    valid_pipe_reg  [STAGES];
    logic [COORD_BITS-1:0]   x_pipe_reg      [STAGES];
    logic [COORD_BITS-1:0]   y_pipe_reg      [STAGES];
    logic [WW-1:0]           weight_pipe_reg [STAGES];
    logic signed [AW-1:0]    acc_pipe_reg    [STAGES-1];
    logic [B-1:0]            ix_reg;
    logic [B-1:0]            iy_reg;
    logic [CW-1:0]           wx_pipe_reg     [1:4];
    logic [CW-1:0]           wy_pipe_reg     [1:6];

    logic signed [31:0]      lat [4][4];
    logic signed [SW-1:0]    smooth_next [4];
    logic signed [SW-1:0]    smooth_reg  [4];
    logic signed [BX_W-1:0]  bx_reg [2];
    logic signed [SW-1:0]    va_reg [2];
    logic signed [BX_W-1:0]  bx_rnd [2];
    logic signed [SW-1:0]    row_next [2];
    logic signed [SW-1:0]    row_reg [2];
    logic signed [BX_W-1:0]  by_reg;
    logic signed [BX_W-1:0]  by_rnd;
    logic signed [SW-1:0]    rtop_reg;
    logic signed [SW-1:0]    r_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [AW-1:0]    term;
    logic signed [AW-1:0]    acc_out_reg;

    assign cx = up_x >> cfg.shift;
    assign cy = up_y >> cfg.shift;
    // left-align the shifted-out fraction bits into the table index
    assign fx = {up_x, {B{1'b0}}} >> cfg.shift;
    assign fy = {up_y, {B{1'b0}}} >> cfg.shift;

    assign wround      = (WW+PW+1)'(up_weight * persistence) + (WW+PW+1)'(32768);
    assign weight_next = wround[WW+15:16];
    assign seeds       = fvnp_pkg::SEED_TAB[cfg.seed];

    genvar i, j;
    generate
        for (i = 0; i < 4; i++)
        begin : g_nb
            assign xs[i] = 32'(cx) + 32'(i) - 32'd1;
            assign ys[i] = 32'(cy) + 32'(i) - 32'd1;
        end
        for (i = 0; i < 4; i++)
        begin : g_hx
            for (j = 0; j < 4; j++)
            begin : g_hy
                fvnp_hash u_hash (
                    .clk   (clk),
                    .en    (en),
                    .cx    (xs[i]),
                    .cy    (ys[j]),
                    .seeds (seeds),
                    .lat   (lat[i][j])
                );
            end
        end
        for (i = 0; i < 2; i++)
        begin : g_sx
            for (j = 0; j < 2; j++)
            begin : g_sy
                assign smooth_next[i+2*j] =
                      SW'(lat[i][j]) + SW'(lat[i+2][j]) + SW'(lat[i][j+2]) + SW'(lat[i+2][j+2])
                    + ((SW'(lat[i+1][j]) + SW'(lat[i+1][j+2])
                        + SW'(lat[i][j+1]) + SW'(lat[i+2][j+1])) <<< 1)
                    + (SW'(lat[i+1][j+1]) <<< 2);
            end
        end
        for (i = 0; i < 2; i++)
        begin : g_row
            assign bx_rnd[i]   = (bx_reg[i] + BX_W'(32768)) >>> 16;
            assign row_next[i] = SW'((SW+1)'(va_reg[i]) + (SW+1)'(bx_rnd[i]));
        end
    endgenerate

    assign by_rnd   = (by_reg + BX_W'(32768)) >>> 16;
    assign prod_rnd = (prod_reg + (PROD_W'(1) <<< 33)) >>> 34;
    assign term     = cfg.active ? AW'(prod_rnd) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STAGES; k++)
                valid_pipe_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            valid_pipe_reg[0] <= up_valid;
            for (int k = 1; k < STAGES; k++)
                valid_pipe_reg[k] <= valid_pipe_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_pipe_reg[0]      <= up_x;
            y_pipe_reg[0]      <= up_y;
            weight_pipe_reg[0] <= weight_next;
            acc_pipe_reg[0]    <= up_acc;
            for (int k = 1; k < STAGES; k++)
            begin
                x_pipe_reg[k]      <= x_pipe_reg[k-1];
                y_pipe_reg[k]      <= y_pipe_reg[k-1];
                weight_pipe_reg[k] <= weight_pipe_reg[k-1];
            end
            for (int k = 1; k < STAGES - 1; k++)
                acc_pipe_reg[k] <= acc_pipe_reg[k-1];

            ix_reg         <= fx[B-1:0];
            iy_reg         <= fy[B-1:0];
            wx_pipe_reg[1] <= COS_ROM[ix_reg];
            wy_pipe_reg[1] <= COS_ROM[iy_reg];
            for (int k = 2; k <= 4; k++)
                wx_pipe_reg[k] <= wx_pipe_reg[k-1];
            for (int k = 2; k <= 6; k++)
                wy_pipe_reg[k] <= wy_pipe_reg[k-1];

            for (int k = 0; k < 4; k++)
                smooth_reg[k] <= smooth_next[k];

            // blend along x on both rows
            bx_reg[0] <= ((SW+1)'(smooth_reg[1]) - (SW+1)'(smooth_reg[0]))
                         * signed'({1'b0, wx_pipe_reg[4]});
            bx_reg[1] <= ((SW+1)'(smooth_reg[3]) - (SW+1)'(smooth_reg[2]))
                         * signed'({1'b0, wx_pipe_reg[4]});
            va_reg[0] <= smooth_reg[0];
            va_reg[1] <= smooth_reg[2];
            row_reg[0] <= row_next[0];
            row_reg[1] <= row_next[1];

            // blend along y
            by_reg   <= ((SW+1)'(row_reg[1]) - (SW+1)'(row_reg[0]))
                        * signed'({1'b0, wy_pipe_reg[6]});
            rtop_reg <= row_reg[0];
            r_reg    <= SW'((SW+1)'(rtop_reg) + (SW+1)'(by_rnd));

            prod_reg    <= r_reg * signed'({1'b0, weight_pipe_reg[8]});
            acc_out_reg <= acc_pipe_reg[STAGES-2] + term;
        end
    end

    assign down_valid  = valid_pipe_reg[STAGES-1];
    assign down_x      = x_pipe_reg[STAGES-1];
    assign down_y      = y_pipe_reg[STAGES-1];
    assign down_weight = weight_pipe_reg[STAGES-1];
    assign down_acc    = acc_out_reg;

endmodule
